### src/mds_pkg.sv
// Shared constants and helpers for the motion step block.
// Holds the fixed-point widths, pipeline depths and the saturation function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mds_pkg;

    localparam int Q_W         = 32;
    localparam int DT_W        = 17;
    localparam logic [DT_W-1:0] DT_RESET = 17'd2185;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 17;
    localparam int LANE_DEPTH  = DIV_STAGES + 5;
    localparam int FRONT_DEPTH = 2;
    localparam int TOTAL_DEPTH = FRONT_DEPTH + SQRT_STAGES + LANE_DEPTH;
    localparam int ACC_W       = 42;
    localparam logic [64:0] Q_ONE_SQ = 65'h1_0000_0000;

    // clamp to the signed Q16.16 range
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [Q_W-1:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/entity_motion_step_with_drag_top.sv
// Top level of the motion step block: squared length, square root, three axis lanes.
// Depends on mds_pkg, mds_isqrt and mds_lane.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     i_valid / o_stall     i_pos_x,y  i_vel_x,y,z  i_accel_x,y,z
// output    o_valid / i_stall     o_new_pos_x,y  o_new_vel_x,y,z
// config    i_cfg_we              i_cfg_data (time step)
//
// One item per cycle unless stalled; the pipeline holds 2 length stages, 32 root stages,
// 17 divider stages and 5 update stages in each lane.
// The whole pipeline advances together; it freezes only while a result waits
// at the output and i_stall is high. Reset clears the valid chain and sets
// the time step to 2185.

module entity_motion_step_with_drag_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mds_pkg::DT_W-1:0]       i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_pos_x,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_pos_y,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_vel_x,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_vel_y,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_vel_z,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_accel_x,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_accel_y,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_accel_z,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [mds_pkg::Q_W-1:0]      o_new_pos_x,
    output logic signed [mds_pkg::Q_W-1:0]      o_new_pos_y,
    output logic signed [mds_pkg::Q_W-1:0]      o_new_vel_x,
    output logic signed [mds_pkg::Q_W-1:0]      o_new_vel_y,
    output logic signed [mds_pkg::Q_W-1:0]      o_new_vel_z
);

    localparam int QW = mds_pkg::Q_W;
    localparam int SQ = mds_pkg::SQRT_STAGES;
    localparam int TD = mds_pkg::TOTAL_DEPTH;

    logic                     c_en;
    logic [TD-1:0]            r_vld;
    logic [mds_pkg::DT_W-1:0] r_time_step;

    assign c_en    = !(r_vld[TD-1] && i_stall);
    assign o_stall = !c_en;
    assign o_valid = r_vld[TD-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_time_step <= mds_pkg::DT_RESET;
        end else begin
            if (c_en) begin
                r_vld <= {r_vld[TD-2:0], i_valid};
            end
            if (i_cfg_we) begin
                r_time_step <= i_cfg_data;
            end
        end
    end

    // stage 1: squares of the acceleration magnitudes
    logic [31:0] c_mx, c_my, c_mz;
    assign c_mx = i_accel_x[QW-1] ? 32'(-i_accel_x) : 32'(i_accel_x);
    assign c_my = i_accel_y[QW-1] ? 32'(-i_accel_y) : 32'(i_accel_y);
    assign c_mz = i_accel_z[QW-1] ? 32'(-i_accel_z) : 32'(i_accel_z);

    logic [63:0] r_sqx, r_sqy, r_sqz;
    logic signed [QW-1:0] r_f1 [8];
    logic signed [QW-1:0] r_f2 [8];
    logic [63:0] r_len;
    logic        r_norm2;
    logic [64:0] c_sum;
    assign c_sum = 65'(r_sqx) + 65'(r_sqy) + 65'(r_sqz);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sqx   <= 64'(c_mx) * 64'(c_mx);
            r_sqy   <= 64'(c_my) * 64'(c_my);
            r_sqz   <= 64'(c_mz) * 64'(c_mz);
            r_f1[0] <= i_pos_x;
            r_f1[1] <= i_pos_y;
            r_f1[2] <= i_vel_x;
            r_f1[3] <= i_vel_y;
            r_f1[4] <= i_vel_z;
            r_f1[5] <= i_accel_x;
            r_f1[6] <= i_accel_y;
            r_f1[7] <= i_accel_z;
            // stage 2: total length and the normalize decision
            r_len   <= c_sum[63:0];
            r_norm2 <= (c_sum > mds_pkg::Q_ONE_SQ);
            r_f2    <= r_f1;
        end
    end

    logic [31:0] c_root;
    mds_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (c_en),
        .i_n    (r_len),
        .o_root (c_root)
    );

    // hold the fields alongside the root pipeline
    logic signed [QW-1:0] r_dly  [SQ][8];
    logic                 r_ndly [SQ];

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_dly[0]  <= r_f2;
            r_ndly[0] <= r_norm2;
            for (int j = 1; j < SQ; j++) begin
                r_dly[j]  <= r_dly[j-1];
                r_ndly[j] <= r_ndly[j-1];
            end
        end
    end

    mds_lane #(.HAS_DRAG(1'b1)) u_lane_x (
        .i_clk     (i_clk),
        .i_en      (c_en),
        .i_dt      (r_time_step),
        .i_norm    (r_ndly[SQ-1]),
        .i_root    (c_root),
        .i_accel   (r_dly[SQ-1][5]),
        .i_vel     (r_dly[SQ-1][2]),
        .i_pos     (r_dly[SQ-1][0]),
        .o_new_vel (o_new_vel_x),
        .o_new_pos (o_new_pos_x)
    );

    mds_lane #(.HAS_DRAG(1'b1)) u_lane_y (
        .i_clk     (i_clk),
        .i_en      (c_en),
        .i_dt      (r_time_step),
        .i_norm    (r_ndly[SQ-1]),
        .i_root    (c_root),
        .i_accel   (r_dly[SQ-1][6]),
        .i_vel     (r_dly[SQ-1][3]),
        .i_pos     (r_dly[SQ-1][1]),
        .o_new_vel (o_new_vel_y),
        .o_new_pos (o_new_pos_y)
    );

    mds_lane #(.HAS_DRAG(1'b0)) u_lane_z (
        .i_clk     (i_clk),
        .i_en      (c_en),
        .i_dt      (r_time_step),
        .i_norm    (r_ndly[SQ-1]),
        .i_root    (c_root),
        .i_accel   (r_dly[SQ-1][7]),
        .i_vel     (r_dly[SQ-1][4]),
        .i_pos     ('0),
        .o_new_vel (o_new_vel_z),
        .o_new_pos ()
    );

endmodule

`default_nettype wire

### src/mds_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses mds_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module mds_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_n,
    output logic [31:0]      o_root
);

    localparam int N = mds_pkg::SQRT_STAGES;

    logic [63:0] r_n    [N];
    logic [34:0] r_rem  [N];
    logic [31:0] r_root [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [63:0] c_n;
            logic [34:0] c_rem;
            logic [31:0] c_root;
            logic [34:0] c_sh;
            logic [34:0] c_trial;
            logic        c_ge;

            if (k == 0) begin : g_first
                assign c_n    = i_n;
                assign c_rem  = '0;
                assign c_root = '0;
            end else begin : g_next
                assign c_n    = r_n[k-1];
                assign c_rem  = r_rem[k-1];
                assign c_root = r_root[k-1];
            end

            // bring down two bits, try root*4+1
            assign c_sh    = {c_rem[32:0], c_n[63:62]};
            assign c_trial = {1'b0, c_root, 2'b01};
            assign c_ge    = (c_sh >= c_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k]    <= {c_n[61:0], 2'b00};
                    r_rem[k]  <= c_ge ? (c_sh - c_trial) : c_sh;
                    r_root[k] <= {c_root[30:0], c_ge};
                end
            end
        end
    endgenerate

    assign o_root = r_root[N-1];

endmodule

`default_nettype wire

### src/mds_lane.sv
// One axis lane: unit-length division, gain and drag, Euler update, saturation.
// Uses mds_pkg for widths, depths and sat32.
`timescale 1ns / 1ps
`default_nettype none

module mds_lane #(
    parameter bit HAS_DRAG = 1'b1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [mds_pkg::DT_W-1:0]      i_dt,
    input  wire logic                          i_norm,
    input  wire logic [31:0]                   i_root,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_accel,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_vel,
    input  wire logic signed [mds_pkg::Q_W-1:0] i_pos,
    output logic signed [mds_pkg::Q_W-1:0]     o_new_vel,
    output logic signed [mds_pkg::Q_W-1:0]     o_new_pos
);

    localparam int N  = mds_pkg::DIV_STAGES;
    localparam int QW = mds_pkg::Q_W;
    localparam int AW = mds_pkg::ACC_W;

    logic [31:0]           r_r     [N];
    logic [N-1:0]          r_q     [N];
    logic [31:0]           r_s     [N];
    logic                  r_norm  [N];
    logic signed [QW-1:0]  r_a     [N];
    logic signed [QW-1:0]  r_v     [N];
    logic signed [QW-1:0]  r_p     [N];

    logic [31:0] c_mag;
    assign c_mag = i_accel[QW-1] ? 32'(-i_accel) : 32'(i_accel);

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_div
            logic [32:0] c_t;
            logic [31:0] c_s;
            logic [N-1:0] c_q;
            logic        c_ge;

            if (k == 0) begin : g_first
                assign c_t = {1'b0, c_mag};
                assign c_s = i_root;
                assign c_q = '0;
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_norm[k] <= i_norm;
                        r_a[k]    <= i_accel;
                        r_v[k]    <= i_vel;
                        r_p[k]    <= i_pos;
                    end
                end
            end else begin : g_next
                assign c_t = {r_r[k-1], 1'b0};
                assign c_s = r_s[k-1];
                assign c_q = r_q[k-1];
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_norm[k] <= r_norm[k-1];
                        r_a[k]    <= r_a[k-1];
                        r_v[k]    <= r_v[k-1];
                        r_p[k]    <= r_p[k-1];
                    end
                end
            end

            assign c_ge = (c_t >= {1'b0, c_s});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k] <= c_ge ? 32'(c_t - {1'b0, c_s}) : c_t[31:0];
                    r_q[k] <= {c_q[N-2:0], c_ge};
                    r_s[k] <= c_s;
                end
            end
        end
    endgenerate

    logic signed [mds_pkg::DT_W:0] c_dt;
    assign c_dt = $signed({1'b0, i_dt});

    // E1: pick the acceleration, apply gain and drag
    logic signed [32:0]   c_aq;
    logic signed [32:0]   c_aeff;
    logic signed [AW-1:0] c_acc;
    assign c_aq   = $signed({16'b0, r_q[N-1]});
    assign c_aeff = !r_norm[N-1] ? 33'(r_a[N-1]) :
                    (r_a[N-1][QW-1] ? -c_aq : c_aq);
    assign c_acc  = AW'(c_aeff) * 42'sd150 -
                    (HAS_DRAG ? AW'(r_v[N-1]) * 42'sd15 : 42'sd0);

    logic signed [AW-1:0] r_acc;
    logic signed [QW-1:0] r_v1, r_p1;

    // E2: scale by dt
    logic signed [59:0] r_prod;
    logic signed [49:0] r_vdt2;
    logic signed [QW-1:0] r_v2, r_p2;

    // E3: velocity gain and new velocity
    logic signed [43:0] c_g;
    logic signed [43:0] r_g;
    logic signed [49:0] r_vdt3;
    logic signed [QW-1:0] r_vel3, r_p3;
    assign c_g = 44'(r_prod >>> 16);

    // E4: gain times dt
    logic signed [61:0] r_gdt;
    logic signed [49:0] r_vdt4;
    logic signed [QW-1:0] r_vel4, r_p4;

    // E5: position sum
    logic signed [63:0] c_twice;
    logic signed [63:0] c_pos;
    assign c_twice = 64'(r_gdt) + 64'(r_vdt4) * 64'sd2;
    assign c_pos   = 64'(r_p4) + (c_twice >>> 17);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc     <= c_acc;
            r_v1      <= r_v[N-1];
            r_p1      <= r_p[N-1];

            r_prod    <= 60'(r_acc) * 60'(c_dt);
            r_vdt2    <= 50'(r_v1) * 50'(c_dt);
            r_v2      <= r_v1;
            r_p2      <= r_p1;

            r_g       <= c_g;
            r_vdt3    <= r_vdt2;
            r_vel3    <= mds_pkg::sat32(64'(r_v2) + 64'(c_g));
            r_p3      <= r_p2;

            r_gdt     <= 62'(r_g) * 62'(c_dt);
            r_vdt4    <= r_vdt3;
            r_vel4    <= r_vel3;
            r_p4      <= r_p3;

            o_new_vel <= r_vel4;
            o_new_pos <= mds_pkg::sat32(c_pos);
        end
    end

endmodule

`default_nettype wire

### dv/mds_checker.sv
// Checker for the motion step block: watches both channels and the config port,
// predicts each result from its own model of the arithmetic and compares.
// Depends on mds_pkg for widths and the reset time step.
`timescale 1ns / 1ps

module mds_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mds_pkg::DT_W-1:0]            i_cfg_data,
    input  logic                                i_valid,
    input  logic                                i_stall_in,
    input  logic signed [mds_pkg::Q_W-1:0]      i_pos_x,
    input  logic signed [mds_pkg::Q_W-1:0]      i_pos_y,
    input  logic signed [mds_pkg::Q_W-1:0]      i_vel_x,
    input  logic signed [mds_pkg::Q_W-1:0]      i_vel_y,
    input  logic signed [mds_pkg::Q_W-1:0]      i_vel_z,
    input  logic signed [mds_pkg::Q_W-1:0]      i_accel_x,
    input  logic signed [mds_pkg::Q_W-1:0]      i_accel_y,
    input  logic signed [mds_pkg::Q_W-1:0]      i_accel_z,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [mds_pkg::Q_W-1:0]      i_new_pos_x,
    input  logic signed [mds_pkg::Q_W-1:0]      i_new_pos_y,
    input  logic signed [mds_pkg::Q_W-1:0]      i_new_vel_x,
    input  logic signed [mds_pkg::Q_W-1:0]      i_new_vel_y,
    input  logic signed [mds_pkg::Q_W-1:0]      i_new_vel_z,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_results
);
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_motion;

    t_motion                  expected_motion[$];
    logic [mds_pkg::DT_W-1:0] dt_model;

    assign o_pending = expected_motion.size();

    function automatic logic signed [31:0] clamp_q(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // floor division by 2^s, arithmetic shift rounds toward minus infinity
    function automatic logic signed [63:0] floor_div(input logic signed [63:0] x,
                                                     input int s);
        return x >>> s;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_motion step_motion(input logic signed [31:0] p[2],
                                            input logic signed [31:0] v[3],
                                            input logic signed [31:0] a_in[3],
                                            input logic [16:0] dt_q);
        logic signed [63:0] a[3];
        logic signed [63:0] g[3];
        logic signed [63:0] acc;
        logic signed [63:0] dt;
        logic signed [63:0] twice;
        logic [63:0]        mag;
        logic [63:0]        len;
        logic [63:0]        root;
        logic signed [31:0] np[2];
        logic signed [31:0] nv[3];
        t_motion            r;
        dt = {47'd0, dt_q};
        len = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = a_in[i];
            mag = a[i] < 0 ? -a[i] : a[i];
            len += mag * mag;
        end
        if (len > 64'h1_0000_0000) begin
            root = int_sqrt(len);
            for (int i = 0; i < 3; i++) begin
                mag = a[i] < 0 ? -a[i] : a[i];
                mag = (mag << 16) / root;
                a[i] = a[i] < 0 ? -$signed(mag) : $signed(mag);
            end
        end
        for (int i = 0; i < 3; i++) begin
            acc = 150 * a[i];
            if (i < 2) acc -= 15 * 64'(v[i]);
            g[i] = floor_div(acc * dt, 16);
            nv[i] = clamp_q(64'(v[i]) + g[i]);
        end
        for (int i = 0; i < 2; i++) begin
            twice = g[i] * dt + 2 * (64'(v[i]) * dt);
            np[i] = clamp_q(64'(p[i]) + floor_div(twice, 17));
        end
        r = '{np[0], np[1], nv[0], nv[1], nv[2]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic signed [31:0] p[2];
        logic signed [31:0] v[3];
        logic signed [31:0] a[3];
        t_motion            want;
        t_motion            got;
        if (!i_rst_n) begin
            dt_model <= mds_pkg::DT_RESET;
            o_errors = 0;
            o_results = 0;
            expected_motion.delete();
        end else begin
            if (i_valid && !i_stall_in) begin
                p = '{i_pos_x, i_pos_y};
                v = '{i_vel_x, i_vel_y, i_vel_z};
                a = '{i_accel_x, i_accel_y, i_accel_z};
                expected_motion.push_back(step_motion(p, v, a, dt_model));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_new_pos_x, i_new_pos_y, i_new_vel_x, i_new_vel_y, i_new_vel_z};
                o_results++;
                if (expected_motion.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_motion.pop_front();
                    if (want !== got) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("result %0d: exp %h %h %h %h %h, got %h %h %h %h %h",
                                o_results, want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                                want.vel_z, got.pos_x, got.pos_y, got.vel_x, got.vel_y,
                                got.vel_z);
                    end
                end
            end
            if (i_cfg_we) dt_model <= i_cfg_data;
        end
    end
endmodule

### dv/tb.sv
// Testbench top for the motion step block: clock, reset, stimulus and verdict.
// Depends on mds_pkg, entity_motion_step_with_drag_top and mds_checker.
`timescale 1ns / 1ps

module tb;
    localparam int LATENCY = 56;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] npx, npy, nvx, nvy, nvz;
    int          errors;
    int          pending;
    int          results;
    bit          hold_off;
    bit          sink_busy;
    int          items_sent;

    entity_motion_step_with_drag_top DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_vel_z(vel_z), .i_accel_x(acc_x), .i_accel_y(acc_y), .i_accel_z(acc_z),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_new_pos_x(npx), .o_new_pos_y(npy), .o_new_vel_x(nvx), .o_new_vel_y(nvy),
        .o_new_vel_z(nvz)
    );

    mds_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_vel_z(vel_z), .i_accel_x(acc_x), .i_accel_y(acc_y), .i_accel_z(acc_z),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_new_pos_x(npx), .i_new_pos_y(npy), .i_new_vel_x(nvx), .i_new_vel_y(nvy),
        .i_new_vel_z(nvz), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("entity_motion_step_with_drag_top: mismatch");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            3: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
            4: return 0;
            default: return $urandom();
        endcase
    endfunction

    // offer one item and hold it until accepted
    task automatic send_motion(input logic signed [31:0] px, py, vx, vy, vz, ax, ay, az);
        pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy; vel_z <= vz;
        acc_x <= ax; acc_y <= ay; acc_z <= az;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input bit with_gaps);
        int gap;
        gap = with_gaps ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        send_motion(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value());
    endtask

    task automatic drain_then_write(input logic [16:0] dt);
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        cfg_we <= 1;
        cfg_data <= dt;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // receiver: random stall per item, or a long hold-off on request
    initial begin
        int wait_n;
        out_stall = 1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1;
                repeat (200) @(negedge clk);
                hold_off = 0;
            end
            wait_n = sink_busy ? $urandom_range(0, 16) : 0;
            if (wait_n > 0) begin
                out_stall <= 1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        logic [16:0] dts[5];
        int          waited;
        dts = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd2185};
        rst_n = 0; cfg_we = 0; cfg_data = 0; in_valid = 0;
        {pos_x, pos_y, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z} = '0;
        hold_off = 0; sink_busy = 0; items_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, unit-length boundary, zero, huge velocities
        send_motion(0, 0, 0, 0, 0, 0, 0, 0);
        send_motion(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_motion(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_motion(100, -100, 32'sh0001_0000, -32'sh0001_0000, 5, 32'sh0001_0000, 0, 0);
        send_motion(0, 0, 0, 0, 0, 32'sh0001_0001, 0, 0);
        send_motion(0, 0, 0, 0, 0, -32'sh0001_0000, 0, -1);
        send_motion(0, 0, 0, 0, 0, 32'sh0000_B505, 32'sh0000_B505, 0);
        send_motion(-5, 7, 32'sh8000_0000, 32'sh7FFF_FFFF, -3, 1, -1, 32'sh8000_0000);
        send_motion(32'sh7FFF_0000, 32'sh8000_FFFF, 32'sh0100_0000, -32'sh0100_0000,
                    32'sh7FFF_FFFF, 0, 0, 0);

        // sweep the time step, extremes included, random items between writes
        for (int ph = 0; ph < 5; ph++) begin
            sink_busy = 1;
            drain_then_write(dts[ph]);
            repeat (6) send_motion(pick_value(), pick_value(), pick_value(), pick_value(),
                                   pick_value(), pick_value(), pick_value(), pick_value());
            for (int k = 0; k < 130; k++) begin
                sink_busy = (k % 50) >= 10;
                send_random(k % 40 >= 8);
            end
            if (ph == 1) begin
                // hold the output long enough to fill the pipeline
                hold_off = 1;
                repeat (120) send_random(0);
            end
            if (ph == 2) begin
                cfg_data <= 17'($urandom_range(0, 131071));
            end
        end
        sink_busy = 1;
        drain_then_write(17'($urandom_range(0, 131071)));
        repeat (40) send_random(1);

        in_valid <= 0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(negedge clk);
            waited++;
        end
        repeat (LATENCY + 20) @(negedge clk);
        $display("sent %0d items over six time steps including 0, 1.0 and the 17-bit max;",
                 items_sent);
        $display("checked %0d results with random gaps, stalls and a full-pipeline hold",
                 results);
        if (errors == 0 && pending == 0) begin
            $display("entity_motion_step_with_drag_top: match");
        end else begin
            $display("entity_motion_step_with_drag_top: mismatch");
        end
        $finish;
    end
endmodule
